[hdl/pps_pkg.sv]
// Shared types, codes and microprogram for the preemptive priority scheduler.
package pps_pkg;

  localparam int RT_W = 16;
  localparam int AT_W = 16;
  localparam int PR_W = 8;
  localparam int TC_W = 5;

  localparam int REG_TASK_COUNT = 0;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_TICK    = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  typedef logic [3:0] step_t;

  localparam step_t S_IDLE    = 4'd0;
  localparam step_t S_LOAD    = 4'd1;
  localparam step_t S_RESTART = 4'd2;
  localparam step_t S_TICK    = 4'd3;
  localparam step_t S_SCAN    = 4'd4;
  localparam step_t S_DRAIN   = 4'd5;
  localparam step_t S_PICK    = 4'd6;
  localparam step_t S_UPD     = 4'd7;
  localparam step_t S_EMIT    = 4'd8;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_GOTO,
    JMP_DISPATCH,
    JMP_SCAN
  } jump_e;

  typedef struct packed {
    jump_e jmp;
    step_t tgt;
    logic  cap;      // capture input word
    logic  wr_load;  // write table entry from captured word
    logic  clr_cnt;  // restart counters
    logic  tick_inc; // advance time, clear scan state
    logic  rd_scan;  // read entry at scan pointer
    logic  rd_best;  // read entry of the pick
    logic  sum_upd;  // fold waiting count into the running sum
    logic  wr_upd;   // write back decremented run time
    logic  emit;     // present result
  } ctrl_t;

  typedef struct packed {
    logic [RT_W-1:0] rem;
    logic [AT_W-1:0] arr;
    logic [PR_W-1:0] pri;
  } entry_t;

  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    w = '0;
    w.jmp = JMP_GOTO;
    w.tgt = S_IDLE;
    case (s)
      S_IDLE: begin
        w.cap = 1'b1;
        w.jmp = JMP_DISPATCH;
      end
      S_LOAD: begin
        w.wr_load = 1'b1;
      end
      S_RESTART: begin
        w.clr_cnt = 1'b1;
      end
      S_TICK: begin
        w.tick_inc = 1'b1;
        w.jmp = JMP_NEXT;
      end
      S_SCAN: begin
        w.rd_scan = 1'b1;
        w.jmp = JMP_SCAN;
      end
      S_DRAIN: begin
        w.jmp = JMP_NEXT;
      end
      S_PICK: begin
        w.rd_best = 1'b1;
        w.sum_upd = 1'b1;
        w.jmp = JMP_NEXT;
      end
      S_UPD: begin
        w.wr_upd = 1'b1;
        w.jmp = JMP_NEXT;
      end
      S_EMIT: begin
        w.emit = 1'b1;
      end
      default: begin
      end
    endcase
    return w;
  endfunction

endpackage

[hdl/pps_cfg.sv]
// APB register slice holding the task count.
module pps_cfg (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output logic [pps_pkg::TC_W-1:0] task_count_o
);

  logic [pps_pkg::TC_W-1:0] task_count_q;
  logic                     sel_tc;

  assign sel_tc = (paddr[2] == 1'(pps_pkg::REG_TASK_COUNT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_count_q <= pps_pkg::TC_W'(1);
    end else if (psel && penable && pwrite && sel_tc) begin
      task_count_q <= pwdata[pps_pkg::TC_W-1:0];
    end
  end

  assign pready       = 1'b1;
  assign prdata       = sel_tc ? 32'(task_count_q) : 32'd0;
  assign task_count_o = task_count_q;

endmodule

[hdl/pps_sequencer.sv]
// Step counter and microprogram fetch with conditional jumps.
module pps_sequencer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [1:0]     operation_i,
  input  logic           scan_last_i,
  output pps_pkg::ctrl_t ctrl_o,
  output logic           busy_o
);

  pps_pkg::step_t step_q, step_d;
  pps_pkg::ctrl_t ctrl;

  assign ctrl = pps_pkg::ucode(step_q);

  always_comb begin
    step_d = step_q;
    case (ctrl.jmp)
      pps_pkg::JMP_NEXT: step_d = step_q + 4'd1;
      pps_pkg::JMP_GOTO: step_d = ctrl.tgt;
      pps_pkg::JMP_DISPATCH: begin
        if (start_i) begin
          case (pps_pkg::op_e'(operation_i))
            pps_pkg::OP_LOAD:    step_d = pps_pkg::S_LOAD;
            pps_pkg::OP_TICK:    step_d = pps_pkg::S_TICK;
            pps_pkg::OP_RESTART: step_d = pps_pkg::S_RESTART;
            default:             step_d = pps_pkg::S_IDLE;
          endcase
        end
      end
      pps_pkg::JMP_SCAN: step_d = scan_last_i ? step_q + 4'd1 : step_q;
      default: step_d = pps_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= pps_pkg::S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = ctrl;
  assign busy_o = (step_q != pps_pkg::S_IDLE);

endmodule

[hdl/pps_datapath.sv]
// Task table, scan/select logic, counters and result registers.
module pps_datapath #(
  parameter int MAX_TASKS = 16,
  parameter int IDX_W     = 4,
  parameter int CNT_W     = 5
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pps_pkg::ctrl_t           ctrl_i,
  input  logic                     start_i,
  input  logic [3:0]               task_index_i,
  input  logic [pps_pkg::RT_W-1:0] run_time_i,
  input  logic [pps_pkg::AT_W-1:0] arrival_tick_i,
  input  logic [pps_pkg::PR_W-1:0] priority_level_i,
  input  logic [pps_pkg::TC_W-1:0] task_count_i,
  output logic                     scan_last_o,
  output logic                     result_valid_o,
  output logic [31:0]              tick_number_o,
  output logic [3:0]               served_index_o,
  output logic                     idle_o,
  output logic                     finished_now_o,
  output logic [4:0]               waiting_now_o,
  output logic [31:0]              waiting_total_o,
  output logic                     all_done_o
);

  // captured input word
  logic [3:0]               tidx_q;
  logic [pps_pkg::RT_W-1:0] rt_q;
  logic [pps_pkg::AT_W-1:0] at_q;
  logic [pps_pkg::PR_W-1:0] pri_q;

  pps_pkg::entry_t mem_q [MAX_TASKS];
  pps_pkg::entry_t rd_q;
  pps_pkg::entry_t wr_data;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic             wr_en;

  logic [MAX_TASKS-1:0] done_q;
  logic [MAX_TASKS-1:0] in_use;
  logic [IDX_W-1:0]     last_idx;
  logic [IDX_W-1:0]     ptr_q, eval_idx_q, best_q, last_pick_q;
  logic                 eval_vld_q;
  logic [pps_pkg::PR_W-1:0] best_pri_q;
  logic                 found_q, finished_q, alldone_q, emit_q;
  logic [CNT_W-1:0]     elig_cnt_q, waiting_q, waiting_d;
  logic [31:0]          tick_q, wsum_q;
  logic [32:0]          wsum_sum;
  logic                 ld_ok, elig, better;
  logic [IDX_W-1:0]     ld_addr;
  logic [pps_pkg::RT_W-1:0] rem_dec;

  // out-of-range task counts clamp to [1, MAX_TASKS]
  always_comb begin
    if (task_count_i == '0) begin
      last_idx = '0;
    end else if (32'(task_count_i) > 32'(MAX_TASKS)) begin
      last_idx = IDX_W'(MAX_TASKS - 1);
    end else begin
      last_idx = IDX_W'(task_count_i - pps_pkg::TC_W'(1));
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      in_use[i] = (32'(i) <= 32'(last_idx));
    end
  end

  assign scan_last_o = (ptr_q == last_idx);
  assign ld_ok       = (32'(tidx_q) < 32'(MAX_TASKS));
  assign ld_addr     = IDX_W'(tidx_q);
  assign rem_dec     = (rd_q.rem != '0) ? rd_q.rem - 1'b1 : '0;

  always_comb begin
    wr_en   = (ctrl_i.wr_load && ld_ok) || (ctrl_i.wr_upd && found_q);
    wr_addr = ctrl_i.wr_load ? ld_addr : best_q;
    if (ctrl_i.wr_load) begin
      wr_data.rem = (rt_q == '0) ? pps_pkg::RT_W'(1) : rt_q;
      wr_data.arr = at_q;
      wr_data.pri = pri_q;
    end else begin
      wr_data.rem = rem_dec;
      wr_data.arr = rd_q.arr;
      wr_data.pri = rd_q.pri;
    end
    rd_addr = ctrl_i.rd_best ? best_q : ptr_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (ctrl_i.rd_scan || ctrl_i.rd_best) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap && start_i) begin
      tidx_q <= task_index_i;
      rt_q   <= run_time_i;
      at_q   <= arrival_tick_i;
      pri_q  <= priority_level_i;
    end
  end

  // evaluation of the entry read in the previous cycle
  assign elig   = eval_vld_q && !done_q[eval_idx_q] && (32'(rd_q.arr) <= tick_q);
  assign better = elig && (rd_q.pri > best_pri_q);

  assign waiting_d = elig_cnt_q - CNT_W'(found_q);
  assign wsum_sum  = {1'b0, wsum_q} + 33'(waiting_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      tick_q      <= '0;
      wsum_q      <= '0;
      last_pick_q <= '0;
      ptr_q       <= '0;
      eval_idx_q  <= '0;
      eval_vld_q  <= 1'b0;
      best_q      <= '0;
      best_pri_q  <= '0;
      found_q     <= 1'b0;
      elig_cnt_q  <= '0;
      waiting_q   <= '0;
      finished_q  <= 1'b0;
      alldone_q   <= 1'b0;
      emit_q      <= 1'b0;
    end else begin
      emit_q     <= ctrl_i.emit;
      eval_vld_q <= ctrl_i.rd_scan;
      eval_idx_q <= ptr_q;

      if (ctrl_i.wr_load && ld_ok) begin
        done_q[ld_addr] <= 1'b0;
      end

      if (ctrl_i.clr_cnt) begin
        tick_q      <= '0;
        wsum_q      <= '0;
        last_pick_q <= '0;
      end

      if (ctrl_i.tick_inc) begin
        if (tick_q != '1) begin
          tick_q <= tick_q + 32'd1;
        end
        ptr_q      <= '0;
        best_q     <= '0;
        best_pri_q <= '0;
        found_q    <= 1'b0;
        elig_cnt_q <= '0;
        finished_q <= 1'b0;
      end

      if (ctrl_i.rd_scan && !scan_last_o) begin
        ptr_q <= ptr_q + 1'b1;
      end

      if (elig) begin
        elig_cnt_q <= elig_cnt_q + 1'b1;
      end
      if (better) begin
        best_q     <= eval_idx_q;
        best_pri_q <= rd_q.pri;
        found_q    <= 1'b1;
      end

      if (ctrl_i.sum_upd) begin
        waiting_q <= waiting_d;
        wsum_q    <= wsum_sum[32] ? '1 : wsum_sum[31:0];
      end

      if (ctrl_i.wr_upd && found_q) begin
        last_pick_q <= best_q;
        if (rem_dec == '0) begin
          done_q[best_q] <= 1'b1;
          finished_q     <= 1'b1;
        end
      end

      if (ctrl_i.emit) begin
        alldone_q <= &(done_q | ~in_use);
      end
    end
  end

  assign result_valid_o  = emit_q;
  assign tick_number_o   = tick_q;
  assign served_index_o  = 4'(last_pick_q);
  assign idle_o          = !found_q;
  assign finished_now_o  = finished_q;
  assign waiting_now_o   = 5'(waiting_q);
  assign waiting_total_o = wsum_q;
  assign all_done_o      = alldone_q;

endmodule

[hdl/preemptive_priority_scheduler.sv]
// Top level: preemptive priority scheduler with APB task-count register.
//
// A word is accepted when start_i is high while busy_o is low. A load or a restart
// keeps busy_o high while its S_LOAD or S_RESTART step runs. A tick reads the task
// table once per entry in use through its single read port, so the time it keeps
// busy_o high grows with the number of entries in use; its result appears on the result
// ports for exactly one cycle, marked by result_valid_o, in the first cycle busy_o
// is low again. The receiver cannot stall that word. Loads and restarts give no
// result. The task count register may be written only while the block is idle.
module preemptive_priority_scheduler #(
  parameter int MAX_TASKS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  operation_i,
  input  logic [3:0]  task_index_i,
  input  logic [15:0] run_time_i,
  input  logic [15:0] arrival_tick_i,
  input  logic [7:0]  priority_level_i,
  output logic        result_valid_o,
  output logic [31:0] tick_number_o,
  output logic [3:0]  served_index_o,
  output logic        idle_o,
  output logic        finished_now_o,
  output logic [4:0]  waiting_now_o,
  output logic [31:0] waiting_total_o,
  output logic        all_done_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  pps_pkg::ctrl_t           ctrl;
  logic                     scan_last;
  logic [pps_pkg::TC_W-1:0] task_count;

  pps_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .task_count_o (task_count)
  );

  pps_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .operation_i (operation_i),
    .scan_last_i (scan_last),
    .ctrl_o      (ctrl),
    .busy_o      (busy_o)
  );

  pps_datapath #(
    .MAX_TASKS (MAX_TASKS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .start_i          (start_i),
    .task_index_i     (task_index_i),
    .run_time_i       (run_time_i),
    .arrival_tick_i   (arrival_tick_i),
    .priority_level_i (priority_level_i),
    .task_count_i     (task_count),
    .scan_last_o      (scan_last),
    .result_valid_o   (result_valid_o),
    .tick_number_o    (tick_number_o),
    .served_index_o   (served_index_o),
    .idle_o           (idle_o),
    .finished_now_o   (finished_now_o),
    .waiting_now_o    (waiting_now_o),
    .waiting_total_o  (waiting_total_o),
    .all_done_o       (all_done_o)
  );

endmodule

[hdl/pps_checker.sv]
// Port-level checks for the scheduler, bound to the top level.
module pps_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic [1:0] operation_i,
  input logic       result_valid_o,
  input logic       idle_o,
  input logic       finished_now_o
);

  // an accepted word with a defined operation makes the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (operation_i == pps_pkg::OP_LOAD ||
                            operation_i == pps_pkg::OP_TICK ||
                            operation_i == pps_pkg::OP_RESTART)) |=> busy_o)
    else $error("busy_o low after accepted word");

  // a result is a one-cycle strobe
  a_strobe_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  // results appear only as the block returns to idle
  a_result_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (!busy_o && $past(busy_o)))
    else $error("result outside end of tick");

  // a tick never completes in the cycle right after acceptance
  a_tick_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && operation_i == pps_pkg::OP_TICK) |=> !result_valid_o)
    else $error("tick result too early");

  // nothing can finish on an idle tick
  a_idle_no_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && idle_o) |-> !finished_now_o)
    else $error("finish reported on idle tick");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .operation_i    (operation_i),
  .result_valid_o (result_valid_o),
  .idle_o         (idle_o),
  .finished_now_o (finished_now_o)
);

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Testbench for the preemptive priority scheduler: directed and random words vs a local model.
module tb;

  localparam int N_TASKS = 16;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 30;
  localparam int PHASE_WORDS = 120;

  typedef struct packed {
    logic [31:0] tick;
    logic [3:0]  served;
    logic        idle;
    logic        finished;
    logic [4:0]  waiting;
    logic [31:0] wait_sum;
    logic        all_done;
  } tick_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  operation_i;
  logic [3:0]  task_index_i;
  logic [15:0] run_time_i;
  logic [15:0] arrival_tick_i;
  logic [7:0]  priority_level_i;
  logic        result_valid_o;
  logic [31:0] tick_number_o;
  logic [3:0]  served_index_o;
  logic        idle_o;
  logic        finished_now_o;
  logic [4:0]  waiting_now_o;
  logic [31:0] waiting_total_o;
  logic        all_done_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  always #5 clk_i = ~clk_i;

  preemptive_priority_scheduler #(.MAX_TASKS(N_TASKS)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .operation_i(operation_i), .task_index_i(task_index_i), .run_time_i(run_time_i),
    .arrival_tick_i(arrival_tick_i), .priority_level_i(priority_level_i),
    .result_valid_o(result_valid_o), .tick_number_o(tick_number_o),
    .served_index_o(served_index_o), .idle_o(idle_o), .finished_now_o(finished_now_o),
    .waiting_now_o(waiting_now_o), .waiting_total_o(waiting_total_o),
    .all_done_o(all_done_o), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // scheduler model state
  logic [15:0] tbl_rem [N_TASKS];
  logic [15:0] tbl_arr [N_TASKS];
  logic [7:0]  tbl_pri [N_TASKS];
  bit          tbl_done [N_TASKS];
  logic [31:0] sched_tick = '0;
  logic [31:0] sched_wait_sum = '0;
  logic [3:0]  sched_last_pick = '0;
  logic [4:0]  task_count_reg = 5'd1;
  bit          sched_all_done = 1'b0;

  tick_report_t tick_reports_q[$];
  tick_report_t want_rep;
  int err_count = 0;
  int words_sent = 0;
  int sender_idle_pct = 0;
  int round_no = 0;

  initial begin
    for (int i = 0; i < N_TASKS; i++) tbl_done[i] = 1'b0;
  end

  task automatic flag_error(input string msg);
    err_count++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic int tasks_active();
    if (task_count_reg == 5'd0) return 1;
    if (int'(task_count_reg) > N_TASKS) return N_TASKS;
    return int'(task_count_reg);
  endfunction

  // returns 1 when the word produces a tick report
  function automatic bit apply_word(input logic [1:0] op, input logic [3:0] idx,
                                    input logic [15:0] rt, input logic [15:0] at,
                                    input logic [7:0] pr, output tick_report_t rep);
    int n;
    int best;
    bit found;
    bit elig;
    logic [7:0] best_pri;
    logic [4:0] waiting;
    logic [32:0] sum;
    rep = '0;
    if (op == pps_pkg::OP_LOAD) begin
      tbl_rem[idx] = (rt == 16'd0) ? 16'd1 : rt;
      tbl_arr[idx] = at;
      tbl_pri[idx] = pr;
      tbl_done[idx] = 1'b0;
      return 1'b0;
    end
    if (op == pps_pkg::OP_RESTART) begin
      sched_tick = '0;
      sched_wait_sum = '0;
      sched_last_pick = '0;
      return 1'b0;
    end
    if (op != pps_pkg::OP_TICK) return 1'b0;

    if (sched_tick != '1) sched_tick++;
    n = tasks_active();
    found = 1'b0;
    best = 0;
    best_pri = '0;
    for (int i = 0; i < n; i++) begin
      elig = !tbl_done[i] && (32'(tbl_arr[i]) <= sched_tick);
      if (elig && tbl_pri[i] > best_pri) begin
        best = i;
        best_pri = tbl_pri[i];
        found = 1'b1;
      end
    end
    waiting = '0;
    for (int i = 0; i < n; i++) begin
      elig = !tbl_done[i] && (32'(tbl_arr[i]) <= sched_tick);
      if (elig && !(found && i == best)) waiting++;
    end
    sum = {1'b0, sched_wait_sum} + 33'(waiting);
    sched_wait_sum = sum[32] ? '1 : sum[31:0];

    if (found) begin
      sched_last_pick = 4'(best);
      if (tbl_rem[best] != 16'd0) tbl_rem[best]--;
      if (tbl_rem[best] == 16'd0) begin
        tbl_done[best] = 1'b1;
        rep.finished = 1'b1;
      end
    end
    sched_all_done = 1'b1;
    for (int i = 0; i < n; i++) if (!tbl_done[i]) sched_all_done = 1'b0;

    rep.tick = sched_tick;
    rep.served = sched_last_pick;
    rep.idle = !found;
    rep.waiting = waiting;
    rep.wait_sum = sched_wait_sum;
    rep.all_done = sched_all_done;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("tick %0d %s got %0h want %0h", want_rep.tick, name, got, want));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (tick_reports_q.size() == 0) begin
        flag_error("tick report with nothing pending");
      end else begin
        want_rep = tick_reports_q.pop_front();
        check_field("tick_number", tick_number_o, want_rep.tick);
        check_field("served_index", 32'(served_index_o), 32'(want_rep.served));
        check_field("idle", 32'(idle_o), 32'(want_rep.idle));
        check_field("finished_now", 32'(finished_now_o), 32'(want_rep.finished));
        check_field("waiting_now", 32'(waiting_now_o), 32'(want_rep.waiting));
        check_field("waiting_total", waiting_total_o, want_rep.wait_sum);
        check_field("all_done", 32'(all_done_o), 32'(want_rep.all_done));
      end
    end
  end

  // start_i is left high on return; the next word takes it over or wait_quiet drops it
  task automatic send_word(input logic [1:0] op, input logic [3:0] idx,
                           input logic [15:0] rt, input logic [15:0] at,
                           input logic [7:0] pr);
    tick_report_t rep;
    while ($urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    operation_i <= op;
    task_index_i <= idx;
    run_time_i <= rt;
    arrival_tick_i <= at;
    priority_level_i <= pr;
    do @(posedge clk_i); while (busy_o);
    if (apply_word(op, idx, rt, at, pr, rep)) tick_reports_q = {tick_reports_q, rep};
    if (op != OP_UNUSED) words_sent++;
  endtask

  task automatic send_tick();
    send_word(pps_pkg::OP_TICK, 4'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic send_restart();
    send_word(pps_pkg::OP_RESTART, 4'($urandom), 16'($urandom), 16'($urandom),
              8'($urandom));
  endtask

  task automatic wait_quiet();
    start_i <= 1'b0;
    while (tick_reports_q.size() != 0) @(posedge clk_i);
    // a load may still be in flight after the last report
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read_check(input logic [2:0] addr, input logic [4:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {27'd0, want})
      flag_error($sformatf("task_count readback got %0h want %0h", prdata, want));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_task_count(input logic [4:0] value);
    wait_quiet();
    apb_write(3'(pps_pkg::REG_TASK_COUNT * 4), {27'd0, value});
    task_count_reg = value;
    apb_read_check(3'(pps_pkg::REG_TASK_COUNT * 4), value);
  endtask

  function automatic logic [15:0] rand_run_time();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 16'd0;
    if (r < 20) return 16'($urandom);
    if (r < 75) return 16'($urandom_range(6, 1));
    return 16'($urandom_range(24, 7));
  endfunction

  function automatic logic [15:0] rand_arrival();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 16'd0;
    if (r < 22) return 16'($urandom);
    return 16'($urandom_range(12));
  endfunction

  // small priorities make ties common
  function automatic logic [7:0] rand_priority();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return 8'd0;
    if (r < 16) return 8'd255;
    if (r < 60) return 8'($urandom_range(4, 1));
    return 8'($urandom_range(255, 1));
  endfunction

  task automatic test_register_reset();
    apb_read_check(3'(pps_pkg::REG_TASK_COUNT * 4), 5'd1);
  endtask

  task automatic test_directed();
    sender_idle_pct = 35;
    // single task, zero run time loads as one
    send_word(pps_pkg::OP_LOAD, 4'd0, 16'd0, 16'd0, 8'd255);
    send_tick();
    send_tick();
    send_word(OP_UNUSED, 4'd5, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_restart();
    send_tick();
    set_task_count(5'd0);
    send_tick();
    set_task_count(5'd3);
    // entry 1 has priority zero: waits, never served until it is reloaded
    send_word(pps_pkg::OP_LOAD, 4'd1, 16'd3, 16'd2, 8'd0);
    send_word(pps_pkg::OP_LOAD, 4'd2, 16'd2, 16'd0, 8'd7);
    send_word(pps_pkg::OP_LOAD, 4'd0, 16'd2, 16'd1, 8'd7);
    // outside the count, still stored
    send_word(pps_pkg::OP_LOAD, 4'd15, 16'hFFFF, 16'hFFFF, 8'd255);
    send_restart();
    repeat (6) send_tick();
    send_word(pps_pkg::OP_LOAD, 4'd1, 16'd1, 16'd0, 8'd1);
    send_tick();
    send_tick();
  endtask

  // every entry written once, so any task count is safe afterwards
  task automatic test_fill_table();
    for (int i = 0; i < N_TASKS; i++)
      send_word(pps_pkg::OP_LOAD, 4'(i), rand_run_time(), rand_arrival(), rand_priority());
  endtask

  task automatic run_round();
    int n;
    int loads;
    int extra;
    int unsigned r;
    logic [4:0] tc;
    logic [3:0] idx;
    case (round_no)
      0: tc = 5'd31;
      1: tc = 5'd16;
      2: tc = 5'd0;
      3: tc = 5'd1;
      default: begin
        r = $urandom_range(9);
        if (r == 0) tc = 5'($urandom_range(31, 17));
        else if (r == 1) tc = 5'd16;
        else if (r == 2) tc = 5'd0;
        else tc = 5'($urandom_range(8, 1));
      end
    endcase
    round_no++;
    set_task_count(tc);
    n = tasks_active();
    loads = $urandom_range(n, 1);
    for (int k = 0; k < loads; k++) begin
      idx = ($urandom_range(7) == 0) ? 4'($urandom) : 4'($urandom_range(n - 1));
      send_word(pps_pkg::OP_LOAD, idx, rand_run_time(), rand_arrival(), rand_priority());
    end
    if ($urandom_range(9) < 7) send_restart();
    extra = 0;
    for (int k = 0; k < 40 && extra < 2; k++) begin
      if ($urandom_range(19) == 0)
        send_word(2'($urandom), 4'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
      send_tick();
      if (sched_all_done) extra++;
    end
  endtask

  task automatic test_random_phase(input int idle_pct);
    int target;
    sender_idle_pct = idle_pct;
    target = words_sent + PHASE_WORDS;
    while (words_sent < target) run_round();
  endtask

  initial begin
    rst_ni <= 1'b0;
    start_i <= 1'b0;
    operation_i <= pps_pkg::OP_LOAD;
    task_index_i <= '0;
    run_time_i <= '0;
    arrival_tick_i <= '0;
    priority_level_i <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_reset();
    test_directed();
    test_fill_table();
    test_random_phase(35);
    test_random_phase(56);
    test_random_phase(0);
    wait_quiet();
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[files.f]
hdl/pps_pkg.sv
hdl/pps_cfg.sv
hdl/pps_sequencer.sv
hdl/pps_datapath.sv
hdl/preemptive_priority_scheduler.sv
hdl/pps_checker.sv
tb/sv/tb.sv
